/* sv/pcgb_pkg.sv */
// Shared types and codes for the point cloud grid binning block.
`timescale 1ns / 1ps
package pcgb_pkg;

    // Operation codes of an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Kind codes of a result item.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CELL   = 1'b1;

    // Configuration register indexes (taken from paddr[2]).
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    // Request to one bin index divider.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

/* sv/pcgb_div.sv */
// Serial bin index unit: one multiply, then one quotient bit per cycle.
`timescale 1ns / 1ps
module pcgb_div
    import pcgb_pkg::*;
#(
    parameter int QW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [QW-1:0] i_mult,
    output logic          o_busy,
    output logic [QW-1:0] o_quot
);

    localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

    logic              r_busy;
    logic              r_mul_ph;
    logic [31+QW:0]    r_prod;
    logic [31:0]       r_rem;
    logic [QW-1:0]     r_low;
    logic [QW-1:0]     r_q;
    logic [31:0]       r_den;
    logic [CNTW-1:0]   r_cnt;

    logic [32:0]       trial;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_low[QW-1]};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_mul_ph <= 1'b0;
        end else if (i_req.start) begin
            r_prod   <= (32 + QW)'(i_req.num) * (32 + QW)'(i_mult);
            r_den    <= i_req.den;
            r_busy   <= 1'b1;
            r_mul_ph <= 1'b1;
        end else if (r_busy) begin
            if (r_mul_ph) begin
                // The high part is already below the divisor, so only QW
                // quotient bits remain to be found.
                r_rem    <= r_prod[31+QW:QW];
                r_low    <= r_prod[QW-1:0];
                r_q      <= '0;
                r_cnt    <= '0;
                r_mul_ph <= 1'b0;
            end else begin
                r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_q   <= (r_q << 1) | QW'(ge);
                r_low <= r_low << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

/* sv/point_cloud_grid_binning.sv */
// Top level of the point cloud grid binning block.
`timescale 1ns / 1ps
// Points arrive as load items and are written to a point memory, one per
// cycle while the block is idle, and the x and y bounds are tracked. The
// first load of a set clears the grid memory with a sweep of one cell per
// cycle; the same sweep runs after reset, and no item is taken during it.
// A load marked last starts the binning: each buffered point is read back,
// two serial dividers compute its row and column (a multiply step, then
// one step per quotient bit, clog2 of the larger grid dimension bits), then
// its cell is read and, if empty, written with the point. The report item
// is shown once every buffered point is binned. A read item returns one
// cell. Any item that ends in a result waits until the output register is
// free. Registers grid_rows (address 0) and grid_cols (address 4) are
// written through the APB port; the user must write them only while the
// block is idle, and the block itself does not enforce this.
module point_cloud_grid_binning
    import pcgb_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_last_point,
    input  logic [4:0]         i_read_row,
    input  logic [4:0]         i_read_col,
    // Result item channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [10:0]        o_skipped_count,
    output logic               o_dropped_flag,
    output logic               o_cell_occupied,
    output logic signed [31:0] o_cell_x,
    output logic signed [31:0] o_cell_y,
    output logic signed [31:0] o_cell_z,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int QW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int GD   = MAX_ROWS * MAX_COLS;
    localparam int CW   = (GD > 1) ? $clog2(GD) : 1;
    localparam int PW   = $clog2(MAX_POINTS + 1);
    localparam int PAW  = $clog2(MAX_POINTS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_ISSUE, S_RD_OUT, S_FETCH, S_PT_WAIT,
        S_DIV, S_GRD_ISSUE, S_GRD, S_REPORT
    } t_state;

    // Two memories: buffered points, and grid cells with a valid bit on top.
    t_point         pt_mem [MAX_POINTS];
    logic [96:0]    grid_mem [GD];

    t_state         r_state;
    logic [5:0]     r_rows;
    logic [5:0]     r_cols;
    logic [PW-1:0]  r_count;
    logic [PW-1:0]  r_bi;
    logic [CW-1:0]  r_clr;
    logic           r_last_pend;
    logic signed [31:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [10:0]    r_coll;
    logic           r_ovf;
    logic [CW-1:0]  r_k;
    logic           r_in_range;
    t_point         r_pt_rd;
    t_point         r_cur;
    logic [96:0]    r_grid_rd;

    logic           r_ovalid;
    logic           r_o_kind;
    logic [10:0]    r_o_skip;
    logic           r_o_drop;
    logic           r_o_occ;
    t_point         r_o_pt;

    logic [QW:0]    rows_eff, cols_eff;
    logic           in_acc, slot_free;
    logic           zero_x, zero_y;
    logic [QW-1:0]  quot_r, quot_c, row_idx, col_idx;
    logic           busy_r, busy_c;
    t_div_req       req_r, req_c;
    logic signed [31:0] base_min_x, base_max_x, base_min_y, base_max_y;
    logic           start_set;
    logic [CW-1:0]  read_k, bin_k;
    logic           grid_we;
    logic [CW-1:0]  grid_waddr;
    logic [96:0]    grid_wdata;
    logic           cfg_we;

    // Register values of 0 act as 1; values past the maximum act as it.
    always_comb begin
        if (r_rows == 6'd0) begin
            rows_eff = (QW + 1)'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            rows_eff = (QW + 1)'(MAX_ROWS);
        end else begin
            rows_eff = (QW + 1)'(r_rows);
        end
        if (r_cols == 6'd0) begin
            cols_eff = (QW + 1)'(1);
        end else if (32'(r_cols) > 32'(MAX_COLS)) begin
            cols_eff = (QW + 1)'(MAX_COLS);
        end else begin
            cols_eff = (QW + 1)'(r_cols);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_ovalid || i_out_ready;
    assign start_set  = (r_count == '0);

    // Bounds as they stand before this point is folded in.
    assign base_min_x = start_set ? i_coord_x : r_min_x;
    assign base_max_x = start_set ? i_coord_x : r_max_x;
    assign base_min_y = start_set ? i_coord_y : r_min_y;
    assign base_max_y = start_set ? i_coord_y : r_max_y;

    assign read_k = CW'(32'(i_read_row) * MAX_COLS + 32'(i_read_col));

    // The dividers start when the point read from memory is in hand.
    assign zero_x = (r_max_x == r_min_x);
    assign zero_y = (r_max_y == r_min_y);
    always_comb begin
        req_r.start = (r_state == S_PT_WAIT);
        req_r.num   = 32'(r_pt_rd.x - r_min_x);
        req_r.den   = 32'(r_max_x - r_min_x);
        req_c.start = (r_state == S_PT_WAIT);
        req_c.num   = 32'(r_pt_rd.y - r_min_y);
        req_c.den   = 32'(r_max_y - r_min_y);
    end

    pcgb_div #(.QW(QW)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_r),
        .i_mult  (QW'(rows_eff - 1'b1)),
        .o_busy  (busy_r),
        .o_quot  (quot_r)
    );

    pcgb_div #(.QW(QW)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_c),
        .i_mult  (QW'(cols_eff - 1'b1)),
        .o_busy  (busy_c),
        .o_quot  (quot_c)
    );

    // A zero range puts every point at index 0.
    assign row_idx = zero_x ? '0 : quot_r;
    assign col_idx = zero_y ? '0 : quot_c;
    assign bin_k   = CW'(32'(row_idx) * MAX_COLS + 32'(col_idx));

    // Grid write port: the clearing sweep, or a first point landing in a cell.
    always_comb begin
        grid_we    = 1'b0;
        grid_waddr = r_k;
        grid_wdata = {1'b1, r_cur};
        if (r_state == S_CLEAR) begin
            grid_we    = 1'b1;
            grid_waddr = r_clr;
            grid_wdata = '0;
        end else if (r_state == S_GRD && !r_grid_rd[96]) begin
            grid_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        r_grid_rd <= grid_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_LOAD && r_count < PW'(MAX_POINTS)) begin
            pt_mem[r_count[PAW-1:0]] <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
        end
        r_pt_rd <= pt_mem[r_bi[PAW-1:0]];
    end

    // Configuration port: always ready, register picked by paddr[2].
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_COLS) ? {26'd0, r_cols} : {26'd0, r_rows};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 6'd10;
            r_cols <= 6'd10;
        end else if (cfg_we) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows <= pwdata[5:0];
            end else begin
                r_cols <= pwdata[5:0];
            end
        end
    end

    // Sequencer for loading, clearing, binning and reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_last_pend <= 1'b0;
            r_count     <= '0;
            r_bi        <= '0;
            r_k         <= '0;
            r_min_x     <= '0;
            r_max_x     <= '0;
            r_min_y     <= '0;
            r_max_y     <= '0;
            r_coll      <= '0;
            r_ovf       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // In the two result states a free slot is refilled in the same
            // cycle, so the valid flag is only dropped elsewhere.
            if (r_ovalid && i_out_ready && r_state != S_RD_OUT
                    && r_state != S_REPORT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == CW'(GD - 1)) begin
                        r_clr <= '0;
                        if (r_last_pend) begin
                            r_bi    <= '0;
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == OP_READ) begin
                            r_k        <= read_k;
                            r_in_range <= (32'(i_read_row) < 32'(rows_eff))
                                       && (32'(i_read_col) < 32'(cols_eff));
                            r_state    <= S_RD_ISSUE;
                        end else begin
                            if (start_set) begin
                                r_coll <= '0;
                            end
                            if (r_count < PW'(MAX_POINTS)) begin
                                r_count <= r_count + 1'b1;
                                r_min_x <= (i_coord_x < base_min_x) ? i_coord_x : base_min_x;
                                r_max_x <= (i_coord_x > base_max_x) ? i_coord_x : base_max_x;
                                r_min_y <= (i_coord_y < base_min_y) ? i_coord_y : base_min_y;
                                r_max_y <= (i_coord_y > base_max_y) ? i_coord_y : base_max_y;
                                r_ovf   <= start_set ? 1'b0 : r_ovf;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                            r_last_pend <= i_last_point;
                            if (start_set) begin
                                r_state <= S_CLEAR;
                            end else if (i_last_point) begin
                                r_bi    <= '0;
                                r_state <= S_FETCH;
                            end
                        end
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_o_kind <= KIND_CELL;
                        r_o_skip <= r_coll;
                        r_o_drop <= r_ovf;
                        if (r_in_range && r_grid_rd[96]) begin
                            r_o_occ <= 1'b1;
                            r_o_pt  <= r_grid_rd[95:0];
                        end else begin
                            r_o_occ <= 1'b0;
                            r_o_pt  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_PT_WAIT;
                end
                S_PT_WAIT: begin
                    r_cur   <= r_pt_rd;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!busy_r && !busy_c) begin
                        r_k     <= bin_k;
                        r_state <= S_GRD_ISSUE;
                    end
                end
                S_GRD_ISSUE: begin
                    r_state <= S_GRD;
                end
                S_GRD: begin
                    // An occupied cell keeps its first point; count the loss.
                    if (r_grid_rd[96] && r_coll != 11'h7FF) begin
                        r_coll <= r_coll + 1'b1;
                    end
                    if (r_bi + 1'b1 == r_count) begin
                        r_state <= S_REPORT;
                    end else begin
                        r_bi    <= r_bi + 1'b1;
                        r_state <= S_FETCH;
                    end
                end
                S_REPORT: begin
                    if (slot_free) begin
                        r_ovalid    <= 1'b1;
                        r_o_kind    <= KIND_REPORT;
                        r_o_skip    <= r_coll;
                        r_o_drop    <= r_ovf;
                        r_o_occ     <= 1'b0;
                        r_o_pt      <= '0;
                        r_count     <= '0;
                        r_last_pend <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_kind          = r_o_kind;
    assign o_skipped_count = r_o_skip;
    assign o_dropped_flag  = r_o_drop;
    assign o_cell_occupied = r_o_occ;
    assign o_cell_x        = r_o_pt.x;
    assign o_cell_y        = r_o_pt.y;
    assign o_cell_z        = r_o_pt.z;

endmodule
